@@ rtl/core/ping_pong_stereo_delay_macros.svh @@
// Assertion helpers for the ping-pong delay core.
`ifndef PING_PONG_STEREO_DELAY_MACROS_SVH
`define PING_PONG_STEREO_DELAY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ppsd_pkg.sv @@
package ppsd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int DEPTH_DEFAULT = 65536;

  // register widths
  localparam int DELAY_W   = 16;
  localparam int FB_W      = 15;
  localparam int WET_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd3;

  // register reset values
  localparam logic               RST_ENABLE   = 1'b0;
  localparam logic [DELAY_W-1:0] RST_DELAY    = 16'd18000;
  localparam logic [FB_W-1:0]    RST_FEEDBACK = 15'd13107;
  localparam logic [WET_W-1:0]   RST_WET      = 16'd9830;

  // Q1.15 unity and derived arithmetic widths
  localparam int                 UNITY_W = 17;
  localparam logic [UNITY_W-1:0] UNITY   = 17'd32768;
  localparam int FBP_W = SAMPLE_BITS + FB_W + 1;
  localparam int MP_W  = SAMPLE_BITS + UNITY_W + 1;
  localparam int SUM_W = MP_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(2**(SAMPLE_BITS-1)));

  // output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int CNT_W       = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_pair_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_pair_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } store_word_t;

  // word in the read-data stage handed to the arithmetic
  typedef struct packed {
    logic    valid;
    logic    en;
    sample_t x_l;
    sample_t x_r;
    sample_t e_l;
    sample_t e_r;
  } s1_t;

  function automatic sample_t sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    begin
      if (v > SAT_MAX) begin
        c = SAT_MAX;
      end else if (v < SAT_MIN) begin
        c = SAT_MIN;
      end else begin
        c = v;
      end
      sat = c[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

@@ rtl/core/ppsd_store.sv @@
module ppsd_store #(
  parameter int DEPTH = ppsd_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output ppsd_pkg::store_word_t      rdata,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  ppsd_pkg::store_word_t      wdata
);
  import ppsd_pkg::*;

  store_word_t mem [DEPTH];
  store_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ppsd_mix.sv @@
module ppsd_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppsd_pkg::s1_t                 s1_i,
  input  logic [ppsd_pkg::FB_W-1:0]     fb_i,
  input  logic [ppsd_pkg::WET_W-1:0]    wet_i,
  output ppsd_pkg::store_word_t         st_o,
  output logic                          res_valid_o,
  output ppsd_pkg::out_pair_t           res_o
);
  import ppsd_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic signed [FBP_W-1:0] fbp_l, fbp_r;
  logic signed [SUM_W-1:0] fbs_l, fbs_r;
  logic signed [SUM_W-1:0] st_sum_l, st_sum_r;
  logic [UNITY_W-1:0]      w_cl, dry;
  logic signed [MP_W-1:0]  pd_l, pd_r, pw_l, pw_r;

  logic                    v_r, en_r;
  sample_t                 x_l_r, x_r_r;
  logic signed [MP_W-1:0]  pd_l_r, pd_r_r, pw_l_r, pw_r_r;
  logic signed [SUM_W-1:0] mix_l, mix_r;

  // cross feedback: left store takes the right echo, right store the left echo
  assign fbp_l = $signed({{(FB_W+1){s1_i.e_r[SB-1]}}, s1_i.e_r})
               * $signed({{(SB+1){1'b0}}, fb_i});
  assign fbp_r = $signed({{(FB_W+1){s1_i.e_l[SB-1]}}, s1_i.e_l})
               * $signed({{(SB+1){1'b0}}, fb_i});
  assign fbs_l = SUM_W'(fbp_l >>> 15);
  assign fbs_r = SUM_W'(fbp_r >>> 15);
  assign st_sum_l = $signed({{(SUM_W-SB){s1_i.x_l[SB-1]}}, s1_i.x_l}) + fbs_l;
  assign st_sum_r = $signed({{(SUM_W-SB){s1_i.x_r[SB-1]}}, s1_i.x_r}) + fbs_r;
  assign st_o.left  = sat(st_sum_l);
  assign st_o.right = sat(st_sum_r);

  // wet above unity counts as unity
  assign w_cl = ({1'b0, wet_i} > UNITY) ? UNITY : {1'b0, wet_i};
  assign dry  = UNITY - w_cl;

  assign pd_l = $signed({{(UNITY_W+1){s1_i.x_l[SB-1]}}, s1_i.x_l})
              * $signed({{(SB+1){1'b0}}, dry});
  assign pd_r = $signed({{(UNITY_W+1){s1_i.x_r[SB-1]}}, s1_i.x_r})
              * $signed({{(SB+1){1'b0}}, dry});
  assign pw_l = $signed({{(UNITY_W+1){s1_i.e_l[SB-1]}}, s1_i.e_l})
              * $signed({{(SB+1){1'b0}}, w_cl});
  assign pw_r = $signed({{(UNITY_W+1){s1_i.e_r[SB-1]}}, s1_i.e_r})
              * $signed({{(SB+1){1'b0}}, w_cl});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= s1_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    en_r   <= s1_i.en;
    x_l_r  <= s1_i.x_l;
    x_r_r  <= s1_i.x_r;
    pd_l_r <= pd_l;
    pd_r_r <= pd_r;
    pw_l_r <= pw_l;
    pw_r_r <= pw_r;
  end

  assign mix_l = (SUM_W'(pd_l_r) + SUM_W'(pw_l_r)) >>> 15;
  assign mix_r = (SUM_W'(pd_r_r) + SUM_W'(pw_r_r)) >>> 15;

  assign res_valid_o     = v_r;
  assign res_o.left_out  = en_r ? sat(mix_l) : x_l_r;
  assign res_o.right_out = en_r ? sat(mix_r) : x_r_r;

endmodule

@@ rtl/core/ppsd_outq.sv @@
module ppsd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ppsd_pkg::out_pair_t  wr_data,
  output logic                 rd_valid,
  input  logic                 rd_pop,
  output ppsd_pkg::out_pair_t  rd_data
);
  import ppsd_pkg::*;

  out_pair_t           q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(wr_en) - CNT_W'(rd_pop);
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = q[rd_ptr_r];

endmodule

@@ rtl/core/ping_pong_stereo_delay.sv @@
// Ping-pong stereo delay with cross feedback and dry/wet mix.
// Input channel: in_valid / in_stall / in_data carry one stereo word (left_in,
// right_in, signed Q1.15). Output channel: out_valid / out_stall / out_data
// carry one mixed word per input word, in order.
// Configuration: cfg_we, cfg_index, cfg_wdata write enable, delay length,
// feedback gain and wet mix; write only while no word is in flight.
// Throughput: one word per cycle while in_stall is low, set by the single read
// and single write port of the shared delay memory (both samples in one word).
// Path: an accepted word passes the memory read stage, the product register
// and the output queue (memory read, feedback and products, mix and saturate).
// Stall: up to four words may be outstanding in the pipeline and the output
// queue; in_stall rises while four are outstanding and drops as words leave.
// Reset: registers go to their defaults, the write pointer to zero. The
// memory is not swept: a fill marker tracks which entries were written since
// reset, and entries not yet written read as zero, so words are accepted
// right after reset. A delay of one reads the word being written in the same
// cycle through a forwarding register.
module ping_pong_stereo_delay #(
  parameter int DEPTH = ppsd_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ppsd_pkg::in_pair_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ppsd_pkg::out_pair_t             out_data,
  input  logic                            cfg_we,
  input  logic [ppsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsd_pkg::CFG_W-1:0]      cfg_wdata
);
  import ppsd_pkg::*;

`include "ping_pong_stereo_delay_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > DELAY_W) ? AW : DELAY_W;

  // configuration registers
  logic               cfg_en_r;
  logic [DELAY_W-1:0] cfg_delay_r;
  logic [FB_W-1:0]    cfg_fb_r;
  logic [WET_W-1:0]   cfg_wet_r;

  // pointer state and fill marker
  logic [AW-1:0]      wp_r;
  logic               full_r;

  // read-data stage
  logic               s1_v_r, s1_en_r, s1_ok_r, fwd_r;
  in_pair_t           s1_x_r;
  logic [AW-1:0]      s1_wa_r;
  store_word_t        fwd_data_r;

  logic [CNT_W-1:0]   total_r;

  logic               in_acc, out_acc;
  logic [CW-1:0]      d_ext;
  logic [AW-1:0]      d_cl, rd_addr;
  logic [AW:0]        diff;
  logic               borrow;
  store_word_t        rdata, st_word, echo;
  s1_t                s1;
  logic               res_valid;
  out_pair_t          res;

  assign in_stall = (total_r == CNT_W'(QUEUE_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r    <= RST_ENABLE;
      cfg_delay_r <= RST_DELAY;
      cfg_fb_r    <= RST_FEEDBACK;
      cfg_wet_r   <= RST_WET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:   cfg_en_r    <= cfg_wdata[0];
        CFG_DELAY:    cfg_delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_FEEDBACK: cfg_fb_r    <= cfg_wdata[FB_W-1:0];
        CFG_WET:      cfg_wet_r   <= cfg_wdata[WET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the delay to 1..DEPTH-1
  always_comb begin
    d_ext = CW'(cfg_delay_r);
    if (d_ext == '0) begin
      d_cl = AW'(1);
    end else if (d_ext > CW'(DEPTH - 1)) begin
      d_cl = AW'(DEPTH - 1);
    end else begin
      d_cl = d_ext[AW-1:0];
    end
  end

  // read address wraps around the circular store
  assign diff    = {1'b0, wp_r} - {1'b0, d_cl};
  assign borrow  = diff[AW];
  assign rd_addr = borrow ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];

  // advance the write pointer only on enabled words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (in_acc && cfg_en_r) begin
      if (wp_r == AW'(DEPTH - 1)) begin
        wp_r   <= '0;
        full_r <= 1'b1;
      end else begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      // read collides with the write landing at the same edge
      fwd_r  <= in_acc && s1_v_r && s1_en_r && (rd_addr == s1_wa_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= st_word;
    if (in_acc) begin
      s1_en_r <= cfg_en_r;
      s1_x_r  <= in_data;
      s1_wa_r <= wp_r;
      // entries below the pointer or any entry after one wrap hold data
      s1_ok_r <= full_r || !borrow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  ppsd_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rdata),
    .we    (s1_v_r && s1_en_r),
    .waddr (s1_wa_r),
    .wdata (st_word)
  );

  always_comb begin
    if (fwd_r) begin
      echo = fwd_data_r;
    end else if (s1_ok_r) begin
      echo = rdata;
    end else begin
      echo = '0;
    end
    s1.valid = s1_v_r;
    s1.en    = s1_en_r;
    s1.x_l   = s1_x_r.left_in;
    s1.x_r   = s1_x_r.right_in;
    s1.e_l   = echo.left;
    s1.e_r   = echo.right;
  end

  ppsd_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_i        (s1),
    .fb_i        (cfg_fb_r),
    .wet_i       (cfg_wet_r),
    .st_o        (st_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ppsd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_valid (out_valid),
    .rd_pop   (out_acc),
    .rd_data  (out_data)
  );

  `PPSD_ASSERT_NOW(a_credit_bound, clk, rst_n, 1'b1, total_r <= CNT_W'(QUEUE_DEPTH), "outstanding words exceed queue depth")
  `PPSD_ASSERT_NOW(a_out_has_word, clk, rst_n, out_valid, total_r != '0, "output valid with no word outstanding")
  `PPSD_ASSERT_NOW(a_fwd_delay_one, clk, rst_n, s1_v_r && fwd_r, d_cl == AW'(1), "forwarding with delay other than one")
  `PPSD_ASSERT_NEXT(a_bypass_holds_wp, clk, rst_n, in_acc && !cfg_en_r, $stable(wp_r), "write pointer moved on a bypass word")

endmodule
